// File: hdl/vtp_pkg.sv
// Shared widths, constants, register indexes and stage payload types
// for the voltage-to-tap pipeline. No dependencies.
package vtp_pkg;

   // Field and datapath widths
   localparam int unsigned CV_W       = 16;  // requested centivolts
   localparam int unsigned CVC_W      = 11;  // clamped centivolts, up to 1500
   localparam int unsigned MV_W       = 14;  // millivolts, up to 15000
   localparam int unsigned BASE_W     = 16;
   localparam int unsigned GAIN_W     = 20;
   localparam int unsigned OFF_W      = 16;
   localparam int unsigned DEN_W      = 14;  // divisor, below 16384 when valid
   localparam int unsigned GK_W       = 30;  // gain times one thousand
   localparam int unsigned NUM_W      = 29;  // rounded dividend, below 2^29 when valid
   localparam int unsigned QUO_W      = 18;  // tap in thousandths, below 2^18
   localparam int unsigned X_W        = 17;  // rounded difference ahead of /1000
   localparam int unsigned RECIP_W    = 18;
   localparam int unsigned PROD_W     = X_W + RECIP_W;
   localparam int unsigned TAP_W      = 7;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 20;
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 8;

   // Arithmetic constants
   localparam int unsigned CV_MIN      = 330;
   localparam int unsigned CV_MAX      = 1500;
   localparam int unsigned MV_PER_CV   = 10;
   localparam int unsigned TAP_MAX     = 127;
   localparam int unsigned MILLI       = 1000;
   localparam int unsigned HALF_MILLI  = 500;
   localparam int unsigned BASE_MIN    = 400;
   localparam int unsigned BASE_MAX    = 1200;
   localparam int unsigned GAIN_MIN    = 100000;
   localparam int unsigned GAIN_MAX    = 500000;
   localparam int unsigned OFFSET_MAX  = 10000;

   // Difference at which the rounded tap reaches TAP_MAX + 1
   localparam int unsigned SAT_LIMIT   = (TAP_MAX + 1) * MILLI - HALF_MILLI;
   // x / 1000 == (x * RECIP) >> RECIP_SHIFT for every x below SAT_LIMIT + HALF_MILLI
   localparam int unsigned RECIP_SHIFT = 27;
   localparam longint unsigned RECIP   = ((64'd1 << RECIP_SHIFT) + MILLI - 1) / MILLI;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAL_INTACT = 2'd0,
      CSR_BASE_MV    = 2'd1,
      CSR_FIT_GAIN   = 2'd2,
      CSR_TAP_OFFSET = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic              ok;
      logic [BASE_W-1:0] base;
      logic [GAIN_W-1:0] gain;
      logic [OFF_W-1:0]  offset;
   } cal_type;

   // Flags that ride along with each item
   typedef struct packed {
      logic rej;    // calibration rejected
      logic below;  // target at or below the base voltage
   } tag_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      tag_type          tag;
   } quot_req_type;

   typedef struct packed {
      logic [QUO_W-1:0] milli;
      tag_type          tag;
   } quot_rsp_type;

endpackage

// File: hdl/vtp_csr.sv
// Calibration registers and their range check.
// Depends on vtp_pkg.
module vtp_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wen,
   input  logic [vtp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vtp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output vtp_pkg::cal_type                cal
);

   logic                         intact_ff;
   logic [vtp_pkg::BASE_W-1:0]   base_ff;
   logic [vtp_pkg::GAIN_W-1:0]   gain_ff;
   logic [vtp_pkg::OFF_W-1:0]    offset_ff;
   logic                         ok_ff, ok_in;

   always_comb begin
      ok_in = intact_ff
         && (base_ff >= vtp_pkg::BASE_W'(vtp_pkg::BASE_MIN))
         && (base_ff <= vtp_pkg::BASE_W'(vtp_pkg::BASE_MAX))
         && (gain_ff >= vtp_pkg::GAIN_W'(vtp_pkg::GAIN_MIN))
         && (gain_ff <= vtp_pkg::GAIN_W'(vtp_pkg::GAIN_MAX))
         && (offset_ff <= vtp_pkg::OFF_W'(vtp_pkg::OFFSET_MAX));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         intact_ff <= 1'b0;
         base_ff   <= '0;
         gain_ff   <= '0;
         offset_ff <= '0;
         ok_ff     <= 1'b0;
      end else begin
         ok_ff <= ok_in;
         if (csr_wen) begin
            case (vtp_pkg::csr_index_type'(csr_index))
               vtp_pkg::CSR_CAL_INTACT: intact_ff <= csr_wdata[0];
               vtp_pkg::CSR_BASE_MV:    base_ff   <= csr_wdata[vtp_pkg::BASE_W-1:0];
               vtp_pkg::CSR_FIT_GAIN:   gain_ff   <= csr_wdata[vtp_pkg::GAIN_W-1:0];
               vtp_pkg::CSR_TAP_OFFSET: offset_ff <= csr_wdata[vtp_pkg::OFF_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign cal = '{ok: ok_ff, base: base_ff, gain: gain_ff, offset: offset_ff};

endmodule

// File: hdl/vtp_front.sv
// Front stages: clamp, scale to millivolts, form divisor and rounded dividend.
// Depends on vtp_pkg.
module vtp_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  logic [vtp_pkg::CV_W-1:0]       in_cv,
   input  vtp_pkg::cal_type               cal,
   output logic                           out_valid,
   output vtp_pkg::quot_req_type          out_req
);

   logic [vtp_pkg::CVC_W-1:0] cvc;
   logic [vtp_pkg::MV_W-1:0]  mv_in, mv_ff;
   logic [vtp_pkg::GK_W-1:0]  gk_in, gk_ff;
   logic                      v1_ff, v2_ff;
   logic [vtp_pkg::DEN_W-1:0] den_in;
   vtp_pkg::quot_req_type     req_in, req_ff;

   // Stage 1: clamp and scale
   always_comb begin
      if (in_cv < vtp_pkg::CV_W'(vtp_pkg::CV_MIN)) begin
         cvc = vtp_pkg::CVC_W'(vtp_pkg::CV_MIN);
      end else if (in_cv > vtp_pkg::CV_W'(vtp_pkg::CV_MAX)) begin
         cvc = vtp_pkg::CVC_W'(vtp_pkg::CV_MAX);
      end else begin
         cvc = in_cv[vtp_pkg::CVC_W-1:0];
      end
      mv_in = vtp_pkg::MV_W'(cvc) * vtp_pkg::MV_W'(vtp_pkg::MV_PER_CV);
      gk_in = vtp_pkg::GK_W'(cal.gain) * vtp_pkg::GK_W'(vtp_pkg::MILLI);
   end

   // Stage 2: divisor and dividend with half-divisor rounding.
   // The range check is registered behind the calibration registers, so
   // sample it here, one stage after the beat enters.
   always_comb begin
      den_in        = mv_ff - cal.base[vtp_pkg::DEN_W-1:0];
      req_in.den    = den_in;
      req_in.num    = gk_ff[vtp_pkg::NUM_W-1:0] + vtp_pkg::NUM_W'(den_in >> 1);
      req_in.tag.rej   = ~cal.ok;
      req_in.tag.below = vtp_pkg::BASE_W'(mv_ff) <= cal.base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mv_ff  <= mv_in;
         gk_ff  <= gk_in;
         req_ff <= req_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_req   = req_ff;

endmodule

// File: hdl/vtp_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on vtp_pkg.
module vtp_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  vtp_pkg::quot_req_type    in_req,
   output logic                     out_valid,
   output vtp_pkg::quot_rsp_type    out_rsp
);

   typedef struct packed {
      logic [vtp_pkg::DEN_W-1:0] rem;
      logic [vtp_pkg::QUO_W-1:0] low;  // dividend bits not yet brought down
      logic [vtp_pkg::QUO_W-1:0] quo;
      logic [vtp_pkg::DEN_W-1:0] den;
      vtp_pkg::tag_type          tag;
   } stage_type;

   stage_type st_ff  [vtp_pkg::QUO_W];
   stage_type st_in  [vtp_pkg::QUO_W];
   logic      vld_ff [vtp_pkg::QUO_W];

   always_comb begin
      stage_type                 src;
      logic [vtp_pkg::DEN_W:0]   trial;
      logic [vtp_pkg::DEN_W+1:0] diff;
      for (int k = 0; k < vtp_pkg::QUO_W; k++) begin
         if (k == 0) begin
            // Quotient fits QUO_W bits, so the top dividend bits stay below den
            src.rem = vtp_pkg::DEN_W'(in_req.num[vtp_pkg::NUM_W-1:vtp_pkg::QUO_W]);
            src.low = in_req.num[vtp_pkg::QUO_W-1:0];
            src.quo = '0;
            src.den = in_req.den;
            src.tag = in_req.tag;
         end else begin
            src = st_ff[k-1];
         end
         trial = {src.rem, src.low[vtp_pkg::QUO_W-1]};
         diff  = {1'b0, trial} - {2'b00, src.den};
         st_in[k]     = src;
         st_in[k].low = src.low << 1;
         if (!diff[vtp_pkg::DEN_W+1]) begin
            st_in[k].rem = diff[vtp_pkg::DEN_W-1:0];
            st_in[k].quo = {src.quo[vtp_pkg::QUO_W-2:0], 1'b1};
         end else begin
            st_in[k].rem = trial[vtp_pkg::DEN_W-1:0];
            st_in[k].quo = {src.quo[vtp_pkg::QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < vtp_pkg::QUO_W; k++) vld_ff[k] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < vtp_pkg::QUO_W; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < vtp_pkg::QUO_W; k++) st_ff[k] <= st_in[k];
      end
   end

   assign out_valid     = vld_ff[vtp_pkg::QUO_W-1];
   assign out_rsp.milli = st_ff[vtp_pkg::QUO_W-1].quo;
   assign out_rsp.tag   = st_ff[vtp_pkg::QUO_W-1].tag;

endmodule

// File: hdl/vtp_back.sv
// Back stages: subtract offset, round to whole taps by reciprocal, saturate.
// Depends on vtp_pkg.
module vtp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  vtp_pkg::quot_rsp_type       in_rsp,
   input  logic [vtp_pkg::OFF_W-1:0]   offset,
   output logic                        out_valid,
   output logic [vtp_pkg::TAP_W-1:0]   out_tap,
   output logic                        out_status
);

   logic [vtp_pkg::QUO_W-1:0]   d;
   logic [vtp_pkg::X_W-1:0]     x_ff;
   logic                        sat_ff, sat_in;
   vtp_pkg::tag_type            taga_ff, tagb_ff;
   logic                        satb_ff;
   logic [vtp_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [vtp_pkg::TAP_W-1:0]   tap_ff, tap_in;
   logic                        status_ff;
   logic                        va_ff, vb_ff, vc_ff;

   // Stage A: clip at zero, detect saturation, add half a tap
   always_comb begin
      if (in_rsp.milli > vtp_pkg::QUO_W'(offset)) begin
         d = in_rsp.milli - vtp_pkg::QUO_W'(offset);
      end else begin
         d = '0;
      end
      sat_in = d >= vtp_pkg::QUO_W'(vtp_pkg::SAT_LIMIT);
   end

   // Stage B: multiply by reciprocal of one thousand
   assign prod_in = vtp_pkg::PROD_W'(x_ff) * vtp_pkg::PROD_W'(vtp_pkg::RECIP);

   // Stage C: select result
   always_comb begin
      if (tagb_ff.rej) begin
         tap_in = '0;
      end else if (tagb_ff.below || satb_ff) begin
         tap_in = vtp_pkg::TAP_W'(vtp_pkg::TAP_MAX);
      end else begin
         tap_in = prod_ff[vtp_pkg::RECIP_SHIFT +: vtp_pkg::TAP_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff      <= vtp_pkg::X_W'(d + vtp_pkg::QUO_W'(vtp_pkg::HALF_MILLI));
         sat_ff    <= sat_in;
         taga_ff   <= in_rsp.tag;
         prod_ff   <= prod_in;
         satb_ff   <= sat_ff;
         tagb_ff   <= taga_ff;
         tap_ff    <= tap_in;
         status_ff <= tagb_ff.rej;
      end
   end

   assign out_valid  = vc_ff;
   assign out_tap    = tap_ff;
   assign out_status = status_ff;

endmodule

// File: hdl/voltage_to_pot_tap_unit.sv
// Pipeline: 2 front stages, 18 divider stages and 3 back stages, ending in the output
// register, lie between an accepted req beat and its rsp beat.
// Throughput: one beat per cycle unless rsp stalls; the 18-stage divider sets depth.
// All stages advance together while the output register is empty or being taken.
// Reset (synchronous, active high) clears all valid bits and the calibration
// registers; the first beat may follow on the next cycle.
module voltage_to_pot_tap_unit (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [vtp_pkg::REQ_DATA_W-1:0]    req_tdata,   // [15:0] target_centivolts
   // Result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [vtp_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [6:0] tap_value, [7] status
   // Calibration write port
   input  logic                              csr_wen,
   input  logic [vtp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [vtp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   vtp_pkg::cal_type              cal;
   vtp_pkg::quot_req_type         quot_req;
   vtp_pkg::quot_rsp_type         quot_rsp;
   logic                          front_valid, div_valid;
   logic                          advance;
   logic [vtp_pkg::TAP_W-1:0]     tap;
   logic                          status;

   // Advance the whole pipe whenever the output register frees up this cycle;
   // bubbles ride along as cleared valid bits.
   assign advance    = ~rsp_tvalid | rsp_tready;
   assign req_tready = advance;

   // Hold calibration registers and the registered range check
   vtp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cal       (cal)
   );

   // Clamp the target, convert to millivolts, build dividend and divisor
   vtp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .in_cv     (req_tdata[vtp_pkg::CV_W-1:0]),
      .cal       (cal),
      .out_valid (front_valid),
      .out_req   (quot_req)
   );

   // Divide gain*1000 (rounded) by the voltage above base, one bit per stage
   vtp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .in_req    (quot_req),
      .out_valid (div_valid),
      .out_rsp   (quot_rsp)
   );

   // Drop the offset, round to taps, saturate and register the result
   vtp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (div_valid),
      .in_rsp     (quot_rsp),
      .offset     (cal.offset),
      .out_valid  (rsp_tvalid),
      .out_tap    (tap),
      .out_status (status)
   );

   assign rsp_tdata = {status, tap};

endmodule

// File: hdl/vtp_checker.sv
// Port-level checks on the voltage-to-tap unit, attached by bind.
// Depends on vtp_pkg and voltage_to_pot_tap_unit.
module vtp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [vtp_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   // Nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp beat valid right after reset");

   // A rejected calibration always reports tap zero
   a_reject_tap: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[7]) |-> (rsp_tdata[6:0] == 7'd0))
      else $error("rejected calibration with nonzero tap");

   // A stalled rsp beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("rsp beat changed while stalled");

   // While the output stalls, no new request enters the pipe
   a_stall_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken while output stalled");

   // Taking the output frees the input in the same cycle
   a_flow: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input blocked while output free");

endmodule

bind voltage_to_pot_tap_unit vtp_checker u_vtp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for voltage_to_pot_tap_unit: streams voltage requests, predicts taps.
// Depends on vtp_pkg and the unit itself; needs no other files.
module tb_top;
   import vtp_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned RANDOM_ITEMS = 1700;
   localparam int unsigned HOLD_CYCLES  = 300;  // long receiver hold-off to back up the pipe
   localparam int unsigned TAIL_CYCLES  = 30;   // tail wait, longer than the pipeline depth

   typedef struct {
      logic [TAP_W-1:0] tap;
      logic             status;
   } tap_result_type;

   // Tracks the calibration registers and holds the tap results still owed by the unit.
   class tap_scoreboard;
      logic              cal_intact;
      logic [BASE_W-1:0] base_mv;
      logic [GAIN_W-1:0] gain;
      logic [OFF_W-1:0]  offset_milli;
      tap_result_type    owed_taps[$];
      int unsigned       mismatches;
      int unsigned       results_seen;

      function new();
         cal_intact   = 1'b0;
         base_mv      = '0;
         gain         = '0;
         offset_milli = '0;
         mismatches   = 0;
         results_seen = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_CAL_INTACT: cal_intact   = value[0];
            CSR_BASE_MV:    base_mv      = value[BASE_W-1:0];
            CSR_FIT_GAIN:   gain         = value[GAIN_W-1:0];
            CSR_TAP_OFFSET: offset_milli = value[OFF_W-1:0];
            default: ;
         endcase
      endfunction

      function tap_result_type predict_tap(logic [CV_W-1:0] cv);
         tap_result_type    r;
         longint unsigned   cvc, mv, den, milli, tapv;
         r.tap    = '0;
         r.status = 1'b1;
         if (!cal_intact || base_mv < BASE_MIN || base_mv > BASE_MAX ||
             gain < GAIN_MIN || gain > GAIN_MAX || offset_milli > OFFSET_MAX)
            return r;
         r.status = 1'b0;
         cvc = 64'(cv);
         if (cvc < CV_MIN) cvc = CV_MIN;
         if (cvc > CV_MAX) cvc = CV_MAX;
         mv = cvc * MV_PER_CV;
         if (mv <= longint'(base_mv)) begin
            tapv = TAP_MAX;
         end else begin
            den   = mv - longint'(base_mv);
            milli = (longint'(gain) * MILLI + den / 2) / den;
            if (milli <= longint'(offset_milli))
               tapv = 0;
            else
               tapv = (milli - longint'(offset_milli) + HALF_MILLI) / MILLI;
            if (tapv > TAP_MAX) tapv = TAP_MAX;
         end
         r.tap = tapv[TAP_W-1:0];
         return r;
      endfunction

      function void note_request(logic [CV_W-1:0] cv);
         owed_taps.push_back(predict_tap(cv));
      endfunction

      function void record_mismatch(string what);
         mismatches++;
         if (mismatches <= 10) $display("[%0t] %s", $time, what);
      endfunction

      function void check_result(logic [TAP_W-1:0] tap, logic status);
         tap_result_type want;
         results_seen++;
         if (owed_taps.size() == 0) begin
            record_mismatch($sformatf("result %0d: unexpected beat, tap %0d status %0d",
                                      results_seen, tap, status));
            return;
         end
         want = owed_taps.pop_front();
         if (want.tap !== tap || want.status !== status)
            record_mismatch($sformatf("result %0d: expected tap %0d status %0d, got tap %0d status %0d",
                                      results_seen, want.tap, want.status, tap, status));
      endfunction

      function int pending();
         return owed_taps.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;    // [15:0] target_centivolts
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;    // [6:0] tap_value, [7] status
   logic                  csr_wen;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tap_scoreboard sb;
   bit            steady;        // no random idling on either side while set
   int unsigned   hold_ticket;   // bump to ask the result side for one long hold-off
   int unsigned   cycle_count;

   voltage_to_pot_tap_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Watchdog: end the run if the traffic never drains.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Offer one request beat and hold it until taken; then maybe leave a gap.
   // Keep tvalid high straight into the next beat when no gap is drawn.
   task automatic send_target(input logic [CV_W-1:0] cv);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= cv;
      do @(posedge clock); while (!req_tready);
      sb.note_request(cv);
      gap = 0;
      if (!steady && $urandom_range(0, 3) == 0)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop tvalid and wait until every owed tap has come back; the unit is idle then.
   task automatic settle_pipeline();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all four calibration registers on back-to-back cycles, enable held high throughout.
   task automatic load_calibration(input logic [CSR_DATA_W-1:0] intact_word,
                                   input logic [CSR_DATA_W-1:0] base_word,
                                   input logic [CSR_DATA_W-1:0] gain_word,
                                   input logic [CSR_DATA_W-1:0] offset_word);
      csr_index_type         order[4];
      logic [CSR_DATA_W-1:0] words[4];
      order = '{CSR_CAL_INTACT, CSR_BASE_MV, CSR_FIT_GAIN, CSR_TAP_OFFSET};
      words = '{intact_word, base_word, gain_word, offset_word};
      for (int i = 0; i < 4; i++) begin
         csr_wen   <= 1'b1;
         csr_index <= order[i];
         csr_wdata <= words[i];
         @(posedge clock);
         sb.write_register(order[i], words[i]);
      end
      csr_wen <= 1'b0;
   endtask

   // Favor the range edges and step just outside them now and then;
   // a full-width draw also exercises the bits the registers drop.
   function automatic logic [CSR_DATA_W-1:0] pick_register_value(int unsigned lo, int unsigned hi);
      int unsigned r;
      r = $urandom_range(0, 19);
      case (r)
         0, 1, 2: return CSR_DATA_W'(lo);
         3, 4, 5: return CSR_DATA_W'(hi);
         6:       return CSR_DATA_W'(lo - 1);
         7:       return CSR_DATA_W'(hi + 1);
         8:       return CSR_DATA_W'($urandom());
         default: return CSR_DATA_W'($urandom_range(lo, hi));
      endcase
   endfunction

   // Mostly the interesting 3.00..15.60 V band, with some low and full-width noise.
   function automatic logic [CV_W-1:0] random_target();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return CV_W'($urandom_range(0, CV_MIN - 1));
      if (r == 1) return CV_W'($urandom());
      return CV_W'($urandom_range(CV_MIN - 30, CV_MAX + 60));
   endfunction

   // Result side: check every taken beat, then decide tready for the next edge.
   initial begin : result_sink
      int unsigned stall_left;
      int unsigned served;
      stall_left = 0;
      served     = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata[TAP_W-1:0], rsp_tdata[TAP_W]);
         if (hold_ticket != served) begin
            // hold off long enough for the pipe to fill and push back on requests
            served     = hold_ticket;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (!steady && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 39) : $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Main sequence: reset, directed corners, then random calibration phases.
   initial begin : stimulus
      int unsigned total;
      int unsigned phase;
      int unsigned count;
      sb          = new();
      steady      = 1'b0;
      hold_ticket = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_wen     = 1'b0;
      csr_index   = CSR_CAL_INTACT;
      csr_wdata   = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers still at reset: calibration rejected, tap forced to zero.
      send_target(16'd0);
      send_target(16'hFFFF);
      settle_pipeline();

      // Highest base and gain, no offset: low targets saturate at the top tap,
      // out-of-range requests clamp to the band edges.
      load_calibration(CSR_DATA_W'(1), CSR_DATA_W'(BASE_MAX), CSR_DATA_W'(GAIN_MAX),
                       CSR_DATA_W'(0));
      send_target(16'd0);
      send_target(CV_W'(CV_MIN - 1));
      send_target(CV_W'(CV_MIN));
      send_target(CV_W'(CV_MIN + 1));
      send_target(16'd1000);
      send_target(CV_W'(CV_MAX - 1));
      send_target(CV_W'(CV_MAX));
      send_target(CV_W'(CV_MAX + 1));
      send_target(16'h7FFF);
      send_target(16'h8000);
      send_target(16'hFFFF);
      settle_pipeline();

      // Lowest base and gain, largest offset: high targets fall to tap zero.
      load_calibration(CSR_DATA_W'(1), CSR_DATA_W'(BASE_MIN), CSR_DATA_W'(GAIN_MIN),
                       CSR_DATA_W'(OFFSET_MAX));
      send_target(CV_W'(CV_MIN));
      send_target(16'd700);
      send_target(CV_W'(CV_MAX));
      send_target(16'hAAAA);
      send_target(16'h5555);
      settle_pipeline();

      // Random calibration per phase; two phases stream flat out against a long hold-off.
      total = 0;
      phase = 0;
      while (total < RANDOM_ITEMS) begin
         load_calibration(CSR_DATA_W'(($urandom() & 32'hFFFFE) |
                                      32'($urandom_range(0, 9) != 0)),
                          pick_register_value(BASE_MIN, BASE_MAX),
                          pick_register_value(GAIN_MIN, GAIN_MAX),
                          pick_register_value(0, OFFSET_MAX));
         steady = (phase == 0 || phase == 5) || ($urandom_range(0, 4) == 0);
         if (phase == 0 || phase == 5) hold_ticket <= hold_ticket + 1;
         count = $urandom_range(80, 160);
         repeat (count) begin
            send_target(random_target());
            total++;
         end
         settle_pipeline();
         phase++;
      end

      steady = 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: voltage_to_pot_tap_unit.f
hdl/vtp_pkg.sv
hdl/vtp_csr.sv
hdl/vtp_front.sv
hdl/vtp_div.sv
hdl/vtp_back.sv
hdl/voltage_to_pot_tap_unit.sv
hdl/vtp_checker.sv
tb/tb_top.sv
